[rtl/wbps_pkg.sv]
// shared types, constants and register codes for the wildcard byte pattern scanner
package wbps_pkg;

  localparam int unsigned PatternMaxDef = 16;
  localparam int unsigned AddrBitsDef   = 32;
  localparam int unsigned PatSlots      = 16;
  localparam int unsigned LenW          = 5;
  localparam int unsigned CfgIndexW     = 3;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned HitAddrW      = 32;

  typedef enum logic [CfgIndexW-1:0] {
    CfgPatLow    = 3'd0,
    CfgPatHigh   = 3'd1,
    CfgWildMask  = 3'd2,
    CfgPatLen    = 3'd3,
    CfgBaseAddr  = 3'd4,
    CfgRelMode   = 3'd5,
    CfgFirstOnly = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       image_last;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [HitAddrW-1:0] hit_address;
    logic                image_done;
    logic                any_found;
  } out_item_t;

  // pattern aligned to window positions, window position 0 is the newest byte
  typedef struct packed {
    logic [PatSlots-1:0][7:0] exp_byte;
    logic [PatSlots-1:0]      care;
    logic [LenW-1:0]          eff_len;
    logic [HitAddrW-1:0]      base_address;
    logic                     relative_mode;
    logic                     first_only;
  } scan_cfg_t;

endpackage

[rtl/wbps_cfg.sv]
// configuration registers and window-aligned pattern compare vectors
module wbps_cfg import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output scan_cfg_t            cfg_o
);

  localparam int unsigned CapLen = (PATTERN_MAX < PatSlots) ? PATTERN_MAX : PatSlots;
  localparam logic [LenW-1:0] CapLenL = LenW'(CapLen);

  logic [63:0]         pat_low_q;
  logic [63:0]         pat_high_q;
  logic [PatSlots-1:0] wild_q;
  logic [LenW-1:0]     len_q;
  logic [31:0]         base_q;
  logic                rel_q;
  logic                first_q;

  logic [PatSlots-1:0][7:0] pat_bytes;
  logic [LenW-1:0]          eff_len;
  logic [LenW-1:0]          idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      wild_q     <= '0;
      len_q      <= LenW'(1);
      base_q     <= '0;
      rel_q      <= 1'b0;
      first_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgPatLow:    pat_low_q  <= cfg_data_i;
        CfgPatHigh:   pat_high_q <= cfg_data_i;
        CfgWildMask:  wild_q     <= cfg_data_i[PatSlots-1:0];
        CfgPatLen:    len_q      <= cfg_data_i[LenW-1:0];
        CfgBaseAddr:  base_q     <= cfg_data_i[31:0];
        CfgRelMode:   rel_q      <= cfg_data_i[0];
        CfgFirstOnly: first_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = {pat_high_q, pat_low_q};
  assign eff_len   = (len_q > CapLenL) ? CapLenL : len_q;

  // window position j holds pattern position eff_len-1-j
  always_comb begin
    cfg_o               = '0;
    cfg_o.eff_len       = eff_len;
    cfg_o.base_address  = base_q;
    cfg_o.relative_mode = rel_q;
    cfg_o.first_only    = first_q;
    idx                 = '0;
    for (int j = 0; j < PatSlots; j++) begin
      idx               = eff_len - LenW'(1) - LenW'(j);
      cfg_o.exp_byte[j] = pat_bytes[idx[3:0]];
      cfg_o.care[j]     = (LenW'(j) < eff_len) && !wild_q[idx[3:0]];
    end
  end

endmodule

[rtl/wbps_scan.sv]
// byte window, fill and offset tracking, masked compare and result formation
module wbps_scan import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef,
  parameter int unsigned ADDR_BITS   = AddrBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  input  scan_cfg_t cfg_i,
  output out_item_t result_o
);

  localparam int unsigned CapLen   = (PATTERN_MAX < PatSlots) ? PATTERN_MAX : PatSlots;
  localparam int unsigned FillW    = $clog2(PATTERN_MAX + 1);
  localparam int unsigned CmpW     = (FillW > LenW) ? FillW : LenW;
  localparam int unsigned AddrKeep = (ADDR_BITS < HitAddrW) ? ADDR_BITS : HitAddrW;
  localparam logic [HitAddrW-1:0] AddrMask = {HitAddrW{1'b1}} >> (HitAddrW - AddrKeep);
  localparam logic [FillW-1:0] FillMax = FillW'(PATTERN_MAX);

  logic [PATTERN_MAX-1:0][7:0] win_q, win_d;
  logic [FillW-1:0]            fill_q, fill_d;
  logic [31:0]                 seen_q;
  logic                        found_q;

  logic                        match;
  logic                        report;
  logic                        found_d;
  logic [CapLen-1:0]           pos_ok;
  logic [31:0]                 offset;
  logic [HitAddrW-1:0]         addr;

  always_comb begin
    win_d[0] = item_i.image_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  assign fill_d = (fill_q == FillMax) ? fill_q : fill_q + FillW'(1);

  always_comb begin
    for (int j = 0; j < CapLen; j++) begin
      pos_ok[j] = !cfg_i.care[j] || (win_d[j] == cfg_i.exp_byte[j]);
    end
  end

  assign match  = (cfg_i.eff_len != '0) && &pos_ok &&
                  (CmpW'(fill_d) >= CmpW'(cfg_i.eff_len));
  assign report = match && !(cfg_i.first_only && found_q);
  assign found_d = found_q || match;

  assign offset = seen_q - {{(32-LenW){1'b0}}, cfg_i.eff_len - LenW'(1)};
  assign addr   = (cfg_i.relative_mode ? offset : cfg_i.base_address + offset) & AddrMask;

  always_comb begin
    result_o             = '0;
    result_o.hit         = report;
    result_o.hit_address = report ? addr : '0;
    result_o.image_done  = item_i.image_last;
    result_o.any_found   = found_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      seen_q  <= '0;
      found_q <= 1'b0;
    end else if (accept_i) begin
      if (item_i.image_last) begin
        fill_q  <= '0;
        seen_q  <= '0;
        found_q <= 1'b0;
      end else begin
        fill_q  <= fill_d;
        seen_q  <= seen_q + 32'd1;
        found_q <= found_d;
      end
    end
  end

endmodule

[rtl/wildcard_byte_pattern_scanner.sv]
// a result is registered and valid in the cycle after its byte request is accepted
// throughput: one byte per cycle, set by the single masked compare and offset add
// but a full result register stalls input only while the output side stalls
// reset clears the window fill, byte count, found flag and output valid
// configuration registers reset to length one, first-only mode, all else zero
module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef,
  parameter int unsigned ADDR_BITS   = AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  scan_cfg_t scan_cfg;
  out_item_t result;
  out_item_t out_data_q;
  logic      out_valid_q;
  logic      in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  wbps_cfg #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (scan_cfg)
  );

  wbps_scan #(
    .PATTERN_MAX(PATTERN_MAX),
    .ADDR_BITS  (ADDR_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .item_i  (in_data_i),
    .cfg_i   (scan_cfg),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/wbps_checker.sv]
// port-level checker for the scanner and its bind
module wbps_checker import wbps_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_hit_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hit) |-> out_data_o.any_found)
    else $error("hit reported without any_found");

  a_no_hit_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |-> (out_data_o.hit_address == '0))
    else $error("nonzero address without hit");

  a_request_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request gave no result next cycle");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with no waiting result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);

[tb/wildcard_byte_pattern_scanner_tb.sv]
// self-checking testbench for the wildcard byte pattern scanner
module wildcard_byte_pattern_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  localparam logic [CfgIndexW-1:0] CfgUnusedIdx = 3'd7;
  localparam int unsigned WinDepth      = 16;
  localparam int unsigned DirectedItems = 25;
  localparam int unsigned RandomItems   = 725;
  localparam int unsigned HoldOffStart  = 300;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned CycleLimit    = 400000;

  typedef enum int unsigned {
    StallNone,
    StallHalf,
    StallLight,
    StallHeavy
  } stall_mode_e;

  class window_matcher;
    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [15:0] wild_mask;
    logic [4:0]  pat_len;
    logic [31:0] base_addr;
    logic        rel_mode;
    logic        first_only;
    logic [7:0]  window [WinDepth];
    logic [31:0] byte_index;
    logic        found;
    int unsigned fill;
    out_item_t   awaited_q[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned hits_seen;

    function new();
      pat_low      = '0;
      pat_high     = '0;
      wild_mask    = '0;
      pat_len      = 5'd1;
      base_addr    = '0;
      rel_mode     = 1'b0;
      first_only   = 1'b1;
      errors       = 0;
      results_seen = 0;
      hits_seen    = 0;
      clear_image();
    endfunction

    function void clear_image();
      foreach (window[i]) window[i] = 8'h00;
      byte_index = '0;
      found      = 1'b0;
      fill       = 0;
    endfunction

    function int unsigned eff_len();
      return (pat_len > 5'd16) ? 16 : pat_len;
    endfunction

    function logic [7:0] pat_byte(int unsigned k);
      return (k < 8) ? pat_low[8*k +: 8] : pat_high[8*(k-8) +: 8];
    endfunction

    function void write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgPatLow:    pat_low = data;
        CfgPatHigh:   pat_high = data;
        CfgWildMask:  wild_mask = data[15:0];
        CfgPatLen:    pat_len = data[4:0];
        CfgBaseAddr:  base_addr = data[31:0];
        CfgRelMode:   rel_mode = data[0];
        CfgFirstOnly: first_only = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(in_item_t req);
      out_item_t   res;
      int unsigned len;
      bit          match;
      logic [31:0] offset;
      for (int i = WinDepth - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = req.image_byte;
      if (fill < WinDepth) fill++;
      len   = eff_len();
      match = (len != 0) && (fill >= len);
      for (int k = 0; k < len; k++) begin
        if (!wild_mask[k] && window[len-1-k] != pat_byte(k)) match = 1'b0;
      end
      res     = '0;
      res.hit = match && !(first_only && found);
      if (res.hit) begin
        offset          = byte_index - (len - 1);
        res.hit_address = rel_mode ? offset : base_addr + offset;
      end
      if (match) found = 1'b1;
      res.image_done = req.image_last;
      res.any_found  = found;
      awaited_q.insert(awaited_q.size(), res);
      byte_index++;
      if (req.image_last) clear_image();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: %s differs on result %0d, got %0h expected %0h",
               $time, what, results_seen, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited_q.size() == 0) begin
        report("unrequested result", got.hit_address, '0);
        return;
      end
      want = awaited_q.pop_front();
      results_seen++;
      if (want.hit) hits_seen++;
      if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
      if (got.hit_address !== want.hit_address)
        report("hit_address", got.hit_address, want.hit_address);
      if (got.image_done !== want.image_done)
        report("image_done", 32'(got.image_done), 32'(want.image_done));
      if (got.any_found !== want.any_found)
        report("any_found", 32'(got.any_found), 32'(want.any_found));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  window_matcher scan = new();
  int unsigned   sent_count    = 0;
  int unsigned   image_count   = 0;
  int unsigned   setting_count = 0;
  int unsigned   burst_left    = 0;
  int unsigned   cycle_count   = 0;
  bit            hold_off_done = 1'b0;

  wildcard_byte_pattern_scanner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("wildcard_byte_pattern_scanner: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) scan.check_result(out_data_o);
  end

  initial begin
    stall_mode_e mode;
    int unsigned span;
    wait (rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          StallNone:  out_stall_i <= 1'b0;
          StallHalf:  out_stall_i <= 1'($urandom_range(0, 1));
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          default:    out_stall_i <= ($urandom_range(0, 5) != 0);
        endcase
      end
      if (!hold_off_done && sent_count >= HoldOffStart) begin
        hold_off_done = 1'b1;
        for (int c = 0; c < HoldOffCycles; c++) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t    req;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req.image_byte = b;
    req.image_last = last;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    scan.note_request(req);
    sent_count++;
    if (last) image_count++;
    burst_left--;
  endtask

  task automatic send_bytes(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (scan.awaited_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    setting_count++;
  endtask

  task automatic cfg_write(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    scan.write_reg(idx, data);
  endtask

  task automatic randomize_settings();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] mask;
    logic [4:0]  len;
    logic [31:0] base;
    int unsigned pick;
    pick = $urandom_range(0, 7);
    lo   = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
    hi   = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
    pick = $urandom_range(0, 5);
    mask = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom & $urandom);
    pick = $urandom_range(0, 9);
    if (pick <= 5) len = 5'($urandom_range(1, 4));
    else if (pick == 6) len = 5'd16;
    else if (pick == 7) len = 5'($urandom_range(17, 31));
    else if (pick == 8) len = 5'd0;
    else len = 5'($urandom_range(5, 15));
    pick = $urandom_range(0, 3);
    base = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
    cfg_write(CfgPatLow, lo);
    cfg_write(CfgPatHigh, hi);
    cfg_write(CfgWildMask, {$urandom, 16'($urandom), mask});
    cfg_write(CfgPatLen, {$urandom, 27'($urandom), len});
    cfg_write(CfgBaseAddr, {$urandom, base});
    cfg_write(CfgRelMode, {$urandom, $urandom});
    cfg_write(CfgFirstOnly, {$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) cfg_write(CfgUnusedIdx, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_image();
    int unsigned n;
    int unsigned len;
    int unsigned plant_pos;
    int unsigned break_at;
    bit          planting;
    bit          broken;
    bit          noise;
    logic [7:0]  b;
    n         = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
    len       = scan.eff_len();
    noise     = ($urandom_range(0, 4) == 0) || (len == 0);
    planting  = 1'b0;
    broken    = 1'b0;
    break_at  = 0;
    plant_pos = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!planting && !noise && $urandom_range(0, 3) == 0) begin
        planting  = 1'b1;
        plant_pos = 0;
        broken    = ($urandom_range(0, 4) == 0);
        break_at  = $urandom_range(0, len - 1);
      end
      if (planting) begin
        b = scan.wild_mask[plant_pos] ? 8'($urandom) : scan.pat_byte(plant_pos);
        if (broken && plant_pos == break_at) b = b ^ (8'h01 << $urandom_range(0, 7));
        plant_pos++;
        if (plant_pos >= len) planting = 1'b0;
      end else if (noise || $urandom_range(0, 1) == 0) begin
        b = 8'($urandom);
      end else begin
        b = scan.pat_byte($urandom_range(0, len - 1));
      end
      send_byte(b, i == n - 1);
    end
  endtask

  initial begin
    logic [7:0]  img[$];
    int unsigned phase_end;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: offset zero hit, then first-only suppression
    img = '{8'h00, 8'hFF, 8'h00};
    send_bytes(img);

    // full-length all-ones pattern with wildcards at both ends
    settle();
    cfg_write(CfgPatLow, '1);
    cfg_write(CfgPatHigh, '1);
    cfg_write(CfgWildMask, 64'h8001);
    cfg_write(CfgPatLen, 64'd16);
    cfg_write(CfgBaseAddr, 64'hFFFF_FFF8);
    cfg_write(CfgRelMode, 64'd0);
    cfg_write(CfgFirstOnly, 64'd0);
    cfg_valid_i <= 1'b0;
    img = '{8'h00};
    repeat (14) img.insert(img.size(), 8'hFF);
    img.insert(img.size(), 8'h00);
    img.insert(img.size(), 8'hFF);
    send_bytes(img);

    // zero length never matches, unused index ignored
    settle();
    cfg_write(CfgPatLen, 64'd0);
    cfg_write(CfgUnusedIdx, '1);
    cfg_valid_i <= 1'b0;
    img = '{8'hFF, 8'hFF};
    send_bytes(img);

    // oversized length clamps to sixteen, short image never matches
    settle();
    cfg_write(CfgPatLen, 64'd31);
    cfg_write(CfgWildMask, 64'hFFFF);
    cfg_write(CfgRelMode, 64'd1);
    cfg_write(CfgFirstOnly, 64'd1);
    cfg_valid_i <= 1'b0;
    img = '{8'h5A, 8'hA5, 8'h3C};
    send_bytes(img);

    while (sent_count < DirectedItems + RandomItems) begin
      settle();
      randomize_settings();
      phase_end = sent_count + $urandom_range(60, 120);
      while (sent_count < phase_end) random_image();
    end

    in_valid_i <= 1'b0;
    while (scan.awaited_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes in %0d images across %0d register settings",
             sent_count, image_count, setting_count);
    $display("checked %0d results, %0d of them reported hits",
             scan.results_seen, scan.hits_seen);
    if (scan.errors == 0) begin
      $display("wildcard_byte_pattern_scanner: match");
    end else begin
      $display("wildcard_byte_pattern_scanner: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/wbps_pkg.sv
rtl/wbps_cfg.sv
rtl/wbps_scan.sv
rtl/wildcard_byte_pattern_scanner.sv
rtl/wbps_checker.sv
tb/wildcard_byte_pattern_scanner_tb.sv
